// File: rtl/core/rpt_pkg.sv
// Package for the remap pair table: field widths, command, status and
// sequencer state codes, and the stored pair type. No dependencies.
package rpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 2'd0,
        CMD_CLEAR_SLOT = 2'd1,
        CMD_CLEAR_ALL  = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_INVALID   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] from_addr;
        logic [ADDR_W-1:0] to_addr;
    } t_pair;

endpackage

// File: rtl/core/rpt_if.sv
// Valid/ready channels of the remap pair table: command items in,
// response items out. Depends on rpt_pkg.
interface rpt_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [rpt_pkg::CMD_W-1:0]  command;
    logic [rpt_pkg::ADDR_W-1:0] from_addr;
    logic [rpt_pkg::ADDR_W-1:0] to_addr;

    modport source (output valid, command, from_addr, to_addr, input ready);
    modport sink   (input valid, command, from_addr, to_addr, output ready);
endinterface

interface rpt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rpt_pkg::STAT_W-1:0]  status;
    logic [rpt_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, status, entry_count, input ready);
    modport sink   (input valid, status, entry_count, output ready);
endinterface

// File: rtl/core/remap_pair_table.sv
// Remap pair table top level: command sequencer, shared pair comparator
// and response register. Depends on rpt_pkg, rpt_if and rpt_pair_mem.
//
// Usage: command items arrive on i_cmd (valid/ready), one response item
// per command leaves on o_rsp (valid/ready). An add checks both addresses
// against addr_max (written through i_cfg_we/i_cfg_wdata), then the fill
// level, then walks the stored pairs for an exact duplicate before
// appending. A clear-slot walks the pairs once and compacts out every pair
// whose target matches. A clear-all only resets the count.
// An add or clear-slot walks the held pairs from the first, one pair
// read per cycle through the single read port; an add that hits a duplicate
// stops early. Rejected adds, clear-all and unused codes skip the walk and go
// straight to the done state. One command is in work at a time:
// i_cmd.ready is high only while the sequencer is idle, so the next command
// can be taken in the cycle after the response registers.
// Reset: synchronous, active low; empties the table and sets addr_max to
// all ones. Table contents are not cleared, only the count.
// Stall: the response register holds its item until o_rsp.ready; a
// finished command waits in place and no new command is taken meanwhile.
module remap_pair_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rpt_cmd_if.sink                    i_cmd,
    rpt_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [rpt_pkg::ADDR_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    rpt_pkg::t_state  r_state, n_state;
    logic             r_is_add, n_is_add;
    logic [rpt_pkg::ADDR_W-1:0] r_from, n_from;
    logic [rpt_pkg::ADDR_W-1:0] r_to, n_to;
    logic [rpt_pkg::ADDR_W-1:0] r_addr_max;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic [CW-1:0]    r_wr_idx, n_wr_idx;
    logic             r_chk, n_chk;
    rpt_pkg::t_status r_status, n_status;
    logic             r_out_valid, n_out_valid;
    rpt_pkg::t_status r_out_status, n_out_status;
    logic [rpt_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    rpt_pkg::t_pair   mem_q;
    rpt_pkg::t_pair   mem_wdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;

    logic cmd_acc;
    logic issue;
    logic cmp_hit;
    logic dup_hit;
    logic scan_end;
    logic out_free;
    logic add_bad;
    logic add_full;

    assign cmd_acc  = i_cmd.valid && i_cmd.ready;
    assign issue    = (r_state == rpt_pkg::S_SCAN) && (r_rd_idx < r_count);
    assign cmp_hit  = (mem_q.to_addr == r_to) && (!r_is_add || mem_q.from_addr == r_from);
    assign dup_hit  = (r_state == rpt_pkg::S_SCAN) && r_chk && r_is_add && cmp_hit;
    assign scan_end = (r_state == rpt_pkg::S_SCAN) && !issue && !r_chk;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign add_bad  = (i_cmd.from_addr > r_addr_max) || (i_cmd.to_addr > r_addr_max);
    assign add_full = r_count >= MAX_CNT;

    rpt_pair_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (mem_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpt_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (rpt_pkg::t_cmd'(i_cmd.command))
                        rpt_pkg::CMD_ADD: begin
                            n_state = (add_bad || add_full) ? rpt_pkg::S_DONE
                                                            : rpt_pkg::S_SCAN;
                        end
                        rpt_pkg::CMD_CLEAR_SLOT: n_state = rpt_pkg::S_SCAN;
                        default:                 n_state = rpt_pkg::S_DONE;
                    endcase
                end
            end
            rpt_pkg::S_SCAN: begin
                if (dup_hit || scan_end) begin
                    n_state = rpt_pkg::S_DONE;
                end
            end
            rpt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rpt_pkg::S_IDLE;
                end
            end
            default: n_state = rpt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_is_add     = r_is_add;
        n_from       = r_from;
        n_to         = r_to;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_chk        = 1'b0;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_wr_idx[AW-1:0];
        mem_wdata    = mem_q;

        unique case (r_state)
            rpt_pkg::S_IDLE: begin
                if (cmd_acc) begin
                    n_from   = i_cmd.from_addr;
                    n_to     = i_cmd.to_addr;
                    n_rd_idx = '0;
                    n_wr_idx = '0;
                    n_status = rpt_pkg::ST_DONE;
                    n_is_add = 1'b0;
                    unique case (rpt_pkg::t_cmd'(i_cmd.command))
                        rpt_pkg::CMD_ADD: begin
                            n_is_add = 1'b1;
                            if (add_bad) begin
                                n_status = rpt_pkg::ST_INVALID;
                            end else if (add_full) begin
                                n_status = rpt_pkg::ST_FULL;
                            end
                        end
                        rpt_pkg::CMD_CLEAR_SLOT: n_is_add = 1'b0;
                        rpt_pkg::CMD_CLEAR_ALL:  n_count  = '0;
                        default:                 n_is_add = 1'b0;
                    endcase
                end
            end
            rpt_pkg::S_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_chk    = 1'b1;
                end
                if (dup_hit) begin
                    n_status = rpt_pkg::ST_DUPLICATE;
                    n_chk    = 1'b0;
                end else if (r_chk && !r_is_add && !cmp_hit) begin
                    // keep this pair: move it down to the write slot
                    mem_we   = 1'b1;
                    n_wr_idx = r_wr_idx + 1'b1;
                end else if (scan_end) begin
                    if (r_is_add) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = '{from_addr: r_from, to_addr: r_to};
                        n_count   = r_count + 1'b1;
                    end else begin
                        n_count = r_wr_idx;
                    end
                end
            end
            rpt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = rpt_pkg::COUNT_W'(r_count);
                end
            end
            default: n_chk = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpt_pkg::S_IDLE;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr_max  <= '1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_addr_max <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_add     <= n_is_add;
        r_from       <= n_from;
        r_to         <= n_to;
        r_rd_idx     <= n_rd_idx;
        r_wr_idx     <= n_wr_idx;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign i_cmd.ready       = (r_state == rpt_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("pair count above table depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpt_pkg::S_SCAN && !r_is_add) |-> (r_wr_idx <= r_rd_idx))
        else $error("compaction write slot ahead of read slot");

    a_add_grows_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpt_pkg::S_SCAN && r_is_add) |=>
            (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1))
        else $error("add changed count by more than one");

    a_done_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpt_pkg::S_DONE) |-> !issue && !mem_we)
        else $error("table access while response pending");

endmodule

// File: rtl/core/rpt_pair_mem.sv
// Pair storage of the remap pair table: one write port, one read port
// with registered read data. Depends on rpt_pkg.
module rpt_pair_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  rpt_pkg::t_pair    i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output rpt_pkg::t_pair    o_rdata
);

    rpt_pkg::t_pair r_mem [DEPTH];
    rpt_pkg::t_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: bench/remap_pair_table_tb.sv
// Self-checking bench for remap_pair_table: a directed table, then random command phases
// under several addr_max settings, each response checked against a pair-table predictor
// or the typed row values. Depends on rpt_pkg, rpt_if and the remap_pair_table RTL.
module remap_pair_table_tb;

    localparam int MAX_ENTRIES     = 64;
    localparam int IDLE_PCT        = 17;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [rpt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [rpt_pkg::CMD_W-1:0]   cmd;
        logic [rpt_pkg::ADDR_W-1:0]  src;
        logic [rpt_pkg::ADDR_W-1:0]  dst;
        bit                          typed;
        rpt_pkg::t_status            status;
        logic [rpt_pkg::COUNT_W-1:0] count;
    } t_row;

    typedef struct packed {
        rpt_pkg::t_status            status;
        logic [rpt_pkg::COUNT_W-1:0] entry_count;
    } t_response;

    typedef struct packed {
        logic [rpt_pkg::CMD_W-1:0]  cmd;
        logic [rpt_pkg::ADDR_W-1:0] src;
        logic [rpt_pkg::ADDR_W-1:0] dst;
    } t_command;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [rpt_pkg::ADDR_W-1:0] cfg_wdata;

    rpt_cmd_if cmd_ch ();
    rpt_rsp_if rsp_ch ();

    remap_pair_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    logic [rpt_pkg::ADDR_W-1:0] pair_from [MAX_ENTRIES];
    logic [rpt_pkg::ADDR_W-1:0] pair_to   [MAX_ENTRIES];
    int                         pair_count;
    logic [rpt_pkg::ADDR_W-1:0] limit_addr;

    t_response   pending_responses [$];
    int          failures;
    int unsigned cycle_count;
    bit          idle_enabled = 1'b1;
    bit          hold_request;
    int          hold_left;

    t_row directed_rows [0:25] = '{
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0000, 16'h0000, 1'b1, rpt_pkg::ST_DONE, 7'd1},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0000, 16'h0000, 1'b1, rpt_pkg::ST_DUPLICATE, 7'd1},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 1'b1, rpt_pkg::ST_DONE, 7'd2},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'hFFFF, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0000, 16'hFFFF, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 1'b1, rpt_pkg::ST_DUPLICATE, 7'd4},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_SLOT, 16'hFFFF, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, CMD_UNUSED, 16'h1234, 16'h5678, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_SLOT, 16'h0000, 16'h5A5A, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_ALL, 16'hFFFF, 16'hFFFF, 1'b1, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_ALL, 16'h0000, 16'h0000, 1'b1, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_SLOT, 16'h0000, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CFG, rpt_pkg::CMD_ADD, 16'h00FF, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0100, 16'h0000, 1'b1, rpt_pkg::ST_INVALID, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0000, 16'h0100, 1'b1, rpt_pkg::ST_INVALID, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 1'b1, rpt_pkg::ST_INVALID, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h00FF, 16'h00FF, 1'b1, rpt_pkg::ST_DONE, 7'd1},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h00FF, 16'h00FF, 1'b1, rpt_pkg::ST_DUPLICATE, 7'd1},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0012, 16'h0034, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0056, 16'h0034, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_SLOT, 16'h0000, 16'h0034, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CFG, rpt_pkg::CMD_ADD, 16'h0000, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0000, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_ADD, 16'h0001, 16'h0000, 1'b1, rpt_pkg::ST_INVALID, 7'd2},
        '{ROW_CFG, rpt_pkg::CMD_ADD, 16'hFFFF, 16'h0000, 1'b0, rpt_pkg::ST_DONE, 7'd0},
        '{ROW_CMD, rpt_pkg::CMD_CLEAR_ALL, 16'h0000, 16'h0000, 1'b1, rpt_pkg::ST_DONE, 7'd0}
    };

    function automatic t_response apply_command(input logic [rpt_pkg::CMD_W-1:0]  cmd,
                                                input logic [rpt_pkg::ADDR_W-1:0] src,
                                                input logic [rpt_pkg::ADDR_W-1:0] dst);
        t_response rsp;
        int        keep;
        rsp.status = rpt_pkg::ST_DONE;
        unique case (cmd)
            rpt_pkg::CMD_ADD: begin
                if (src > limit_addr || dst > limit_addr) begin
                    rsp.status = rpt_pkg::ST_INVALID;
                end else if (pair_count >= MAX_ENTRIES) begin
                    rsp.status = rpt_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < pair_count; i++) begin
                        if (pair_from[i] == src && pair_to[i] == dst) begin
                            rsp.status = rpt_pkg::ST_DUPLICATE;
                        end
                    end
                    if (rsp.status == rpt_pkg::ST_DONE) begin
                        pair_from[pair_count] = src;
                        pair_to[pair_count]   = dst;
                        pair_count++;
                    end
                end
            end
            rpt_pkg::CMD_CLEAR_SLOT: begin
                keep = 0;
                for (int r = 0; r < pair_count; r++) begin
                    if (pair_to[r] != dst) begin
                        pair_from[keep] = pair_from[r];
                        pair_to[keep]   = pair_to[r];
                        keep++;
                    end
                end
                pair_count = keep;
            end
            rpt_pkg::CMD_CLEAR_ALL: begin
                pair_count = 0;
            end
            default: begin
            end
        endcase
        rsp.entry_count = rpt_pkg::COUNT_W'(pair_count);
        return rsp;
    endfunction

    function automatic logic [rpt_pkg::ADDR_W-1:0] pick_addr();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) begin
            return rpt_pkg::ADDR_W'($urandom_range(15));
        end
        if (r < 60) begin
            return limit_addr + rpt_pkg::ADDR_W'($urandom_range(4)) - rpt_pkg::ADDR_W'(2);
        end
        return rpt_pkg::ADDR_W'($urandom_range(16'hFFFF));
    endfunction

    // fill-heavy phases push toward a full table; mixed phases exercise removal
    function automatic t_command random_command(input bit fill_heavy);
        t_command    c;
        int unsigned r;
        int          idx;
        r     = $urandom_range(99);
        c.cmd = rpt_pkg::CMD_ADD;
        c.src = pick_addr();
        c.dst = pick_addr();
        if (fill_heavy) begin
            if (r >= 97) begin
                c.cmd = CMD_UNUSED;
            end else if (r >= 93) begin
                c.cmd = rpt_pkg::CMD_CLEAR_SLOT;
            end else if (r >= 85) begin
                r = 65;
            end
        end else begin
            if (r >= 95) begin
                c.cmd = CMD_UNUSED;
            end else if (r >= 92) begin
                c.cmd = rpt_pkg::CMD_CLEAR_ALL;
            end else if (r >= 75) begin
                c.cmd = rpt_pkg::CMD_CLEAR_SLOT;
            end
        end
        if (pair_count > 0) begin
            idx = $urandom_range(pair_count - 1);
            if (c.cmd == rpt_pkg::CMD_ADD && r >= 55 && r < 75) begin
                c.src = pair_from[idx];
                c.dst = pair_to[idx];
            end else if (c.cmd == rpt_pkg::CMD_CLEAR_SLOT && $urandom_range(99) < 70) begin
                c.dst = pair_to[idx];
            end
        end
        return c;
    endfunction

    task automatic send_command(input logic [rpt_pkg::CMD_W-1:0]  cmd,
                                input logic [rpt_pkg::ADDR_W-1:0] src,
                                input logic [rpt_pkg::ADDR_W-1:0] dst,
                                input bit                         typed,
                                input t_response                  typed_rsp);
        t_response predicted;
        while (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.from_addr <= src;
        cmd_ch.to_addr   <= dst;
        do @(posedge clk); while (!cmd_ch.ready);
        predicted = apply_command(cmd, src, dst);
        pending_responses.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic drain_responses();
        cmd_ch.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_addr_max(input logic [rpt_pkg::ADDR_W-1:0] value);
        drain_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        limit_addr  = value;
    endtask

    task automatic check_response();
        t_response want;
        if (pending_responses.size() == 0) begin
            $display("%0t: unexpected response, status %0d count %0d",
                     $time, rsp_ch.status, rsp_ch.entry_count);
            failures++;
        end else begin
            want = pending_responses.pop_front();
            if (rsp_ch.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, rsp_ch.status);
                failures++;
            end
            if (rsp_ch.entry_count !== want.entry_count) begin
                $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                         $time, want.entry_count, rsp_ch.entry_count);
                failures++;
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("remap_pair_table_tb NOT OK");
            $finish;
        end
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                check_response();
            end
            if (hold_request && hold_left == 0) begin
                hold_left = RSP_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    hold_request = 1'b0;
                end
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= !idle_enabled || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        logic [rpt_pkg::ADDR_W-1:0] addr_max_plan [PHASES];
        t_command                   next_cmd;
        addr_max_plan    = '{16'hFFFF, 16'h0000, 16'h1000, 16'h000F, 16'hFFFE, 16'hFFFF};
        addr_max_plan[2] = rpt_pkg::ADDR_W'($urandom_range(16'hFFFE, 16'h0010));
        pair_count       = 0;
        limit_addr       = '1;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.command   <= rpt_pkg::CMD_ADD;
        cmd_ch.from_addr <= '0;
        cmd_ch.to_addr   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_addr_max(directed_rows[i].src);
            end else begin
                send_command(directed_rows[i].cmd, directed_rows[i].src, directed_rows[i].dst,
                             directed_rows[i].typed,
                             '{directed_rows[i].status, directed_rows[i].count});
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_addr_max(addr_max_plan[p]);
            idle_enabled = (p != 3);
            if (p == 0) begin
                hold_request = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                next_cmd = random_command(p == 0 || p == 1 || p == 4);
                send_command(next_cmd.cmd, next_cmd.src, next_cmd.dst, 1'b0, '0);
            end
        end

        drain_responses();
        repeat (10) @(posedge clk);
        if (failures == 0) begin
            $display("remap_pair_table_tb OK");
        end else begin
            $display("remap_pair_table_tb NOT OK");
        end
        $finish;
    end
endmodule
